// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_OFF
// Check that a property holds at every rising clock edge outside reset.
`define SWHC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a condition never becomes true outside reset.
`define SWHC_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SWHC_ASSERT(lbl, clk, rst_n, prop)
`define SWHC_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== rtl/swhc_pkg.sv =====
package swhc_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 512;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int OCC_W      = $clog2(RING_DEPTH + 1);

  // Field widths
  localparam int TS_W    = 31;
  localparam int CNT_W   = 32;
  localparam int WIN_W   = 10;
  localparam int ENTRY_W = TS_W + CNT_W;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_WINDOW_IDX = 1'b0;
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(300);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    CMD_HIT   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef logic [IDX_W-1:0] idx_t;

  // Memory access from the sequencer; entry word is {second, count}
  typedef struct packed {
    logic               rd_en;
    idx_t               rd_addr;
    logic               wr_en;
    idx_t               wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } mem_req_t;

  // Advance a ring index with wrap
  function automatic idx_t ring_next(input idx_t i);
    idx_t r;
    if (i == IDX_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/sliding_window_hit_counter.sv =====
// A query word is posted on out_hit_total, strobed by out_valid, after the retire walk has
// dropped the stale ring entries; start is taken only while busy is low. The retire walk
// reads one head entry per cycle through the single read port of the ring memory.
// Reset (rst_n low, synchronous) empties the ring and sets window_r to 300.
// Results are strobed for one cycle and cannot be stalled by the receiver.
module sliding_window_hit_counter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [swhc_pkg::TS_W-1:0]         in_timestamp,
  output logic                              out_valid,
  output logic [swhc_pkg::CNT_W-1:0]        out_hit_total,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swhc_pkg::PADDR_W-1:0]      paddr,
  input  logic [swhc_pkg::PDATA_W-1:0]      pwdata,
  output logic [swhc_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  logic [swhc_pkg::WIN_W-1:0]   window_r;
  logic                         reg_sel;
  swhc_pkg::mem_req_t           req;
  logic [swhc_pkg::ENTRY_W-1:0] rd_data;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == swhc_pkg::REG_WINDOW_IDX);

  // Take window writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= swhc_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      window_r <= pwdata[swhc_pkg::WIN_W-1:0];
    end
  end

  assign prdata = reg_sel ? swhc_pkg::PDATA_W'(window_r) : '0;

  swhc_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_command    (in_command),
    .in_timestamp  (in_timestamp),
    .window        (window_r),
    .rd_data       (rd_data),
    .req           (req),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_hit_total (out_hit_total)
  );

  swhc_ring u_ring (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

// ===== rtl/swhc_ring.sv =====
module swhc_ring (
  input  logic                          clk,
  input  swhc_pkg::mem_req_t            req,
  output logic [swhc_pkg::ENTRY_W-1:0]  rd_data
);

  logic [swhc_pkg::ENTRY_W-1:0] mem [swhc_pkg::RING_DEPTH];
  logic [swhc_pkg::ENTRY_W-1:0] rd_data_r;

  // Write one entry, read one entry with a registered word
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/swhc_seq.sv =====
`include "assert_macros.svh"

module swhc_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             in_command,
  input  logic [swhc_pkg::TS_W-1:0]        in_timestamp,
  input  logic [swhc_pkg::WIN_W-1:0]       window,
  input  logic [swhc_pkg::ENTRY_W-1:0]     rd_data,
  output swhc_pkg::mem_req_t               req,
  output logic                             busy,
  output logic                             out_valid,
  output logic [swhc_pkg::CNT_W-1:0]       out_hit_total
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RETIRE,
    S_ACT
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            cmd_r, cmd_nxt;
  logic [swhc_pkg::TS_W-1:0]       ts_r, ts_nxt;
  swhc_pkg::idx_t                  head_r, head_nxt;
  swhc_pkg::idx_t                  tail_r, tail_nxt;
  swhc_pkg::idx_t                  last_r, last_nxt;
  logic [swhc_pkg::OCC_W-1:0]      occ_r, occ_nxt;
  logic [swhc_pkg::CNT_W-1:0]      total_r, total_nxt;
  logic [swhc_pkg::TS_W-1:0]       tail_sec_r, tail_sec_nxt;
  logic [swhc_pkg::CNT_W-1:0]      tail_cnt_r, tail_cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [swhc_pkg::CNT_W-1:0]      out_total_r, out_total_nxt;

  logic [swhc_pkg::TS_W-1:0]       rd_sec;
  logic [swhc_pkg::CNT_W-1:0]      rd_cnt;
  logic [swhc_pkg::TS_W-1:0]       age;
  logic                            retire_ok;
  logic                            do_act;

  assign rd_sec = rd_data[swhc_pkg::ENTRY_W-1:swhc_pkg::CNT_W];
  assign rd_cnt = rd_data[swhc_pkg::CNT_W-1:0];

  // Head entry is stale once it is a full window behind the timestamp
  assign age       = ts_r - rd_sec;
  assign retire_ok = (ts_r >= rd_sec) && (age >= swhc_pkg::TS_W'(window));

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    ts_nxt        = ts_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    last_nxt      = last_r;
    occ_nxt       = occ_r;
    total_nxt     = total_r;
    tail_sec_nxt  = tail_sec_r;
    tail_cnt_nxt  = tail_cnt_r;
    out_valid_nxt = 1'b0;
    out_total_nxt = out_total_r;
    req           = '0;
    do_act        = 1'b0;

    // Retire walk: one head entry per cycle
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          ts_nxt  = in_timestamp;
          if (occ_r != '0) begin
            req.rd_en   = 1'b1;
            req.rd_addr = head_r;
            state_nxt   = S_RETIRE;
          end else begin
            state_nxt = S_ACT;
          end
        end
      end
      S_RETIRE: begin
        if (retire_ok) begin
          total_nxt = total_r - rd_cnt;
          head_nxt  = swhc_pkg::ring_next(head_r);
          occ_nxt   = swhc_pkg::OCC_W'(occ_r - 1'b1);
          if (occ_r > swhc_pkg::OCC_W'(1)) begin
            req.rd_en   = 1'b1;
            req.rd_addr = head_nxt;
          end else begin
            state_nxt = S_ACT;
          end
        end else begin
          do_act    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ACT: begin
        do_act    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Query: post the total; hit: bump tail or append, skipped when full
    if (do_act) begin
      if (cmd_r == swhc_pkg::CMD_QUERY) begin
        out_valid_nxt = 1'b1;
        out_total_nxt = total_r;
      end else if (total_r != swhc_pkg::COUNT_MAX) begin
        if ((occ_r != '0) && (tail_sec_r == ts_r)) begin
          if (tail_cnt_r != swhc_pkg::COUNT_MAX) begin
            tail_cnt_nxt = tail_cnt_r + 1'b1;
            total_nxt    = total_r + 1'b1;
            req.wr_en    = 1'b1;
            req.wr_addr  = last_r;
            req.wr_data  = {ts_r, tail_cnt_nxt};
          end
        end else if (occ_r != swhc_pkg::OCC_W'(swhc_pkg::RING_DEPTH)) begin
          tail_sec_nxt = ts_r;
          tail_cnt_nxt = swhc_pkg::CNT_W'(1);
          total_nxt    = total_r + 1'b1;
          occ_nxt      = occ_r + 1'b1;
          last_nxt     = tail_r;
          tail_nxt     = swhc_pkg::ring_next(tail_r);
          req.wr_en    = 1'b1;
          req.wr_addr  = tail_r;
          req.wr_data  = {ts_r, swhc_pkg::CNT_W'(1)};
        end
      end
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      ts_r        <= ts_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      last_r      <= last_nxt;
      occ_r       <= occ_nxt;
      total_r     <= total_nxt;
      tail_sec_r  <= tail_sec_nxt;
      tail_cnt_r  <= tail_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_total_r <= out_total_nxt;
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_hit_total = out_total_r;

  `SWHC_ASSERT(a_occ_bound, clk, rst_n, occ_r <= swhc_pkg::OCC_W'(swhc_pkg::RING_DEPTH))
  `SWHC_ASSERT(a_empty_ptrs, clk, rst_n, (occ_r == '0) |-> (head_r == tail_r))
  `SWHC_NEVER(a_rd_wr_clash, clk, rst_n, req.rd_en && req.wr_en)
  `SWHC_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)

endmodule
